// ===== hdl/ftr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flat triangle rasterizer package
// shared constants, operation codes and transaction types
// ----------------------------------------------------------------------------
package ftr_pkg;

  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int COL_W       = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W       = $clog2(MAX_HEIGHT + 1);

  localparam int CFG_W       = 9;
  localparam int CFG_RESET   = 256;
  localparam int COLOUR_W    = 24;

  // screen coordinates in 1/32768 pixel units
  localparam int COORD_W     = 26;
  localparam int MUL_W       = 27;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int EDGE_W      = 56;
  localparam int HALF_UNIT   = 16384;
  localparam int PIX_SHIFT   = 15;

  localparam logic [1:0] OP_DRAW  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] bx;
    logic signed [15:0] by;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic [7:0]         fill_red;
    logic [7:0]         fill_green;
    logic [7:0]         fill_blue;
    logic [15:0]        pixel_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } out_item_t;

endpackage

// ===== hdl/flat_triangle_rasterizer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flat triangle rasterizer
// frame store with flat-colour triangle fill, pixel read and clear to black
//
//   channel   direction  handshake                  payload
//   item      in         item_valid / item_stall    ftr_pkg::in_item_t
//   result    out        result_valid / result_stall ftr_pkg::out_item_t
//   cfg       in         cfg_write_enable           cfg_index, cfg_data
//
// draw: set-up on one shared multiplier, then each pixel of the clamped screen,
//   one pixel a cycle, through the edge-function accumulators and the store port
// read: a store read, then a load of the result register
// clear: one store entry a cycle over all STORE_DEPTH entries (65536)
// after reset the same clearing pass runs before any item
// is taken; a read waits while the result register is still held by stall
// ----------------------------------------------------------------------------
module flat_triangle_rasterizer_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  ftr_pkg::in_item_t            item,
  output logic                         result_valid,
  input  logic                         result_stall,
  output ftr_pkg::out_item_t           result,
  input  logic                         cfg_write_enable,
  input  logic                         cfg_index,
  input  logic [ftr_pkg::CFG_W-1:0]    cfg_data
);

  localparam int AW = ftr_pkg::ADDR_W;
  localparam int EW = ftr_pkg::EDGE_W;
  localparam int CW = ftr_pkg::COORD_W;
  localparam int MW = ftr_pkg::MUL_W;
  localparam int PW = ftr_pkg::PROD_W;
  localparam logic [3:0] STEP_AREA = 4'd13;
  localparam logic [3:0] STEP_LAST = 4'd14;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_RASTER,
    ST_READ
  } state_t;

  state_t                        state;
  logic [ftr_pkg::CFG_W-1:0]     screen_width;
  logic [ftr_pkg::CFG_W-1:0]     screen_height;
  logic [ftr_pkg::CFG_W-1:0]     w;
  logic [ftr_pkg::CFG_W-1:0]     h;

  logic [ftr_pkg::COLOUR_W-1:0]  frame_store [ftr_pkg::STORE_DEPTH];
  logic [ftr_pkg::COLOUR_W-1:0]  rd_data;
  logic                          rd_en;
  logic [AW-1:0]                 rd_addr;
  logic [31:0]                   pix_wide;
  logic                          wr_en;
  logic [ftr_pkg::COLOUR_W-1:0]  wr_data;

  logic [AW-1:0]                 sweep_addr;
  logic [ftr_pkg::COL_W-1:0]     col;
  logic [ftr_pkg::ROW_W-1:0]     row;
  logic                          col_last;
  logic                          row_last;
  logic                          sweep_last;
  logic                          read_zero;
  logic [ftr_pkg::COLOUR_W-1:0]  colour;

  logic [3:0]                    step;
  logic signed [15:0]            vx [3];
  logic signed [15:0]            vy [3];
  logic signed [CW-1:0]          x [3];
  logic signed [CW-1:0]          y [3];
  logic signed [MW-1:0]          mul_a;
  logic signed [MW-1:0]          mul_b;
  logic signed [PW-1:0]          prod;
  logic signed [CW-1:0]          mapped;

  logic signed [EW-1:0]          c [3];
  logic signed [EW-1:0]          e [3];
  logic signed [EW-1:0]          er [3];
  logic signed [EW-1:0]          da [3];
  logic signed [EW-1:0]          db [3];
  logic signed [EW-1:0]          area;
  logic                          area_neg;
  logic                          covered;
  logic                          accept;
  logic                          result_free;

  // clamp screen size to the store
  assign w = (32'(screen_width) > 32'(ftr_pkg::MAX_WIDTH)) ?
             ftr_pkg::CFG_W'(ftr_pkg::MAX_WIDTH) : screen_width;
  assign h = (32'(screen_height) > 32'(ftr_pkg::MAX_HEIGHT)) ?
             ftr_pkg::CFG_W'(ftr_pkg::MAX_HEIGHT) : screen_height;

  assign item_stall  = (state != ST_IDLE);
  assign accept      = item_valid && (state == ST_IDLE);
  assign result_free = !result_valid || !result_stall;

  assign pix_wide = {16'd0, item.pixel_index};
  assign rd_addr  = pix_wide[AW-1:0];
  assign rd_en    = accept && (item.op == ftr_pkg::OP_READ);

  assign col_last   = (32'(col) + 32'd1 == 32'(w));
  assign row_last   = (32'(row) + 32'd1 == 32'(h));
  assign sweep_last = (sweep_addr == AW'(ftr_pkg::STORE_DEPTH - 1));

  // pixel centre test: all edges share the sign of the area or are zero
  always_comb begin
    if (area_neg) begin
      covered = (e[0][EW-1] || e[0] == '0) && (e[1][EW-1] || e[1] == '0) &&
                (e[2][EW-1] || e[2] == '0);
    end else begin
      covered = !e[0][EW-1] && !e[1][EW-1] && !e[2][EW-1];
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_data = colour;
    unique case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_data = '0;
      end
      ST_RASTER: begin
        wr_en   = covered;
      end
      default: begin
        wr_en   = 1'b0;
      end
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (step)
      4'd0: begin
        mul_a = MW'(vx[0]) + MW'(ftr_pkg::HALF_UNIT);
        mul_b = MW'($signed({1'b0, w}));
      end
      4'd1: begin
        mul_a = MW'(vy[0]) + MW'(ftr_pkg::HALF_UNIT);
        mul_b = MW'($signed({1'b0, h}));
      end
      4'd2: begin
        mul_a = MW'(vx[1]) + MW'(ftr_pkg::HALF_UNIT);
        mul_b = MW'($signed({1'b0, w}));
      end
      4'd3: begin
        mul_a = MW'(vy[1]) + MW'(ftr_pkg::HALF_UNIT);
        mul_b = MW'($signed({1'b0, h}));
      end
      4'd4: begin
        mul_a = MW'(vx[2]) + MW'(ftr_pkg::HALF_UNIT);
        mul_b = MW'($signed({1'b0, w}));
      end
      4'd5: begin
        mul_a = MW'(vy[2]) + MW'(ftr_pkg::HALF_UNIT);
        mul_b = MW'($signed({1'b0, h}));
      end
      4'd6: begin
        mul_a = MW'(x[0]);
        mul_b = MW'(y[1]);
      end
      4'd7: begin
        mul_a = MW'(y[0]);
        mul_b = MW'(x[1]);
      end
      4'd8: begin
        mul_a = MW'(x[2]);
        mul_b = MW'(y[0]);
      end
      4'd9: begin
        mul_a = MW'(x[0]);
        mul_b = MW'(y[2]);
      end
      4'd10: begin
        mul_a = MW'(x[1]);
        mul_b = MW'(y[2]);
      end
      4'd11: begin
        mul_a = MW'(y[1]);
        mul_b = MW'(x[2]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mapped = CW'(prod - PW'(ftr_pkg::HALF_UNIT));

  // frame store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame_store[sweep_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= frame_store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // control and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      sweep_addr    <= '0;
      result_valid  <= 1'b0;
      screen_width  <= ftr_pkg::CFG_W'(ftr_pkg::CFG_RESET);
      screen_height <= ftr_pkg::CFG_W'(ftr_pkg::CFG_RESET);
      step          <= '0;
    end else begin
      if (cfg_write_enable) begin
        unique case (cfg_index)
          ftr_pkg::REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
          ftr_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_data;
          default: begin
          end
        endcase
      end

      if (result_valid && !result_stall && state != ST_READ) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        ST_CLEAR: begin
          sweep_addr <= sweep_addr + AW'(1);
          if (sweep_last) begin
            state <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (item_valid) begin
            vx[0]     <= item.ax;
            vy[0]     <= item.ay;
            vx[1]     <= item.bx;
            vy[1]     <= item.by;
            vx[2]     <= item.cx;
            vy[2]     <= item.cy;
            colour    <= {item.fill_red, item.fill_green, item.fill_blue};
            read_zero <= (32'(item.pixel_index) >= 32'(ftr_pkg::STORE_DEPTH));
            step      <= '0;
            unique case (item.op)
              ftr_pkg::OP_DRAW:  state <= ST_SETUP;
              ftr_pkg::OP_READ:  state <= ST_READ;
              ftr_pkg::OP_CLEAR: begin
                state      <= ST_CLEAR;
                sweep_addr <= '0;
              end
              default:           state <= ST_IDLE;
            endcase
          end
        end

        ST_SETUP: begin
          step <= step + 4'd1;
          unique case (step)
            4'd1:  x[0] <= mapped;
            4'd2:  y[0] <= mapped;
            4'd3:  x[1] <= mapped;
            4'd4:  y[1] <= mapped;
            4'd5:  x[2] <= mapped;
            4'd6:  y[2] <= mapped;
            4'd7:  c[2] <= EW'(prod);
            4'd8:  c[2] <= c[2] - EW'(prod);
            4'd9:  c[1] <= EW'(prod);
            4'd10: c[1] <= c[1] - EW'(prod);
            4'd11: c[0] <= EW'(prod);
            4'd12: c[0] <= c[0] - EW'(prod);
            default: begin
            end
          endcase
          if (step == STEP_AREA) begin
            area  <= c[0] + c[1] + c[2];
            da[0] <= EW'(y[1] - y[2]) <<< ftr_pkg::PIX_SHIFT;
            db[0] <= EW'(x[2] - x[1]) <<< ftr_pkg::PIX_SHIFT;
            da[1] <= EW'(y[2] - y[0]) <<< ftr_pkg::PIX_SHIFT;
            db[1] <= EW'(x[0] - x[2]) <<< ftr_pkg::PIX_SHIFT;
            da[2] <= EW'(y[0] - y[1]) <<< ftr_pkg::PIX_SHIFT;
            db[2] <= EW'(x[1] - x[0]) <<< ftr_pkg::PIX_SHIFT;
            for (int k = 0; k < 3; k++) begin
              e[k]  <= c[k];
              er[k] <= c[k];
            end
          end
          if (step == STEP_LAST) begin
            area_neg   <= area[EW-1];
            col        <= '0;
            row        <= '0;
            sweep_addr <= '0;
            if (area == '0 || w == '0 || h == '0) begin
              state <= ST_IDLE;
            end else begin
              state <= ST_RASTER;
            end
          end
        end

        ST_RASTER: begin
          sweep_addr <= sweep_addr + AW'(1);
          if (col_last) begin
            col <= '0;
            if (row_last) begin
              state <= ST_IDLE;
            end else begin
              row <= row + ftr_pkg::ROW_W'(1);
              for (int k = 0; k < 3; k++) begin
                er[k] <= er[k] + db[k];
                e[k]  <= er[k] + db[k];
              end
            end
          end else begin
            col <= col + ftr_pkg::COL_W'(1);
            for (int k = 0; k < 3; k++) begin
              e[k] <= e[k] + da[k];
            end
          end
        end

        ST_READ: begin
          if (result_free) begin
            result_valid     <= 1'b1;
            result.out_red   <= read_zero ? 8'd0 : rd_data[23:16];
            result.out_green <= read_zero ? 8'd0 : rd_data[15:8];
            result.out_blue  <= read_zero ? 8'd0 : rd_data[7:0];
            state            <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
